// File: hw/rtl/rtq_pkg.sv
// Shared types and defaults for the retransmit timer queue.
// Holds the operation and status codes and the cell control struct.
// No dependencies.
package rtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int RETRY_BITS      = 8;

  localparam int PORT_TIME_BITS   = 32;
  localparam int PORT_HANDLE_BITS = 16;
  localparam int PORT_OCC_BITS    = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_PEEK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic by_handle;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/rtq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbours.
// Depends on rtq_pkg.
module rtq_cell import rtq_pkg::*; #(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic [TIME_BITS-1:0]   cmd_time,
  input  logic [HANDLE_BITS-1:0] cmd_handle,
  input  logic [RETRY_BITS-1:0]  cmd_retries,
  input  logic                   prev_valid,
  input  logic [TIME_BITS-1:0]   prev_time,
  input  logic [HANDLE_BITS-1:0] prev_handle,
  input  logic [RETRY_BITS-1:0]  prev_retries,
  input  logic                   prev_le,
  input  logic                   next_valid,
  input  logic [TIME_BITS-1:0]   next_time,
  input  logic [HANDLE_BITS-1:0] next_handle,
  input  logic [RETRY_BITS-1:0]  next_retries,
  input  logic                   seen_in,
  output logic                   seen_out,
  output logic                   le,
  output logic                   valid,
  output logic [TIME_BITS-1:0]   entry_time,
  output logic [HANDLE_BITS-1:0] entry_handle,
  output logic [RETRY_BITS-1:0]  entry_retries
);

  logic hit;
  logic del_here;

  assign le       = valid && (entry_time <= cmd_time);
  assign hit      = valid && (!ctrl.by_handle || (entry_handle == cmd_handle));
  assign del_here = seen_in || hit;
  assign seen_out = del_here;

  always_ff @(posedge clk) begin
    if (ctrl.ins && !le) begin
      if (prev_le) begin
        entry_time    <= cmd_time;
        entry_handle  <= cmd_handle;
        entry_retries <= cmd_retries;
      end else begin
        entry_time    <= prev_time;
        entry_handle  <= prev_handle;
        entry_retries <= prev_retries;
      end
    end else if (ctrl.del && del_here) begin
      entry_time    <= next_time;
      entry_handle  <= next_handle;
      entry_retries <= next_retries;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins && !le) begin
      valid <= prev_le ? 1'b1 : prev_valid;
    end else if (ctrl.del && del_here) begin
      valid <= next_valid;
    end
  end

endmodule

// File: hw/rtl/retransmit_timer_queue.sv
// Top level of the retransmit timer queue: command register, row of cells, result.
// Depends on rtq_pkg and rtq_cell.
//
//   channel   handshake          payload
//   command   start / busy       kind, due_time, packet_handle, retry_count
//   result    done (strobe)      head_valid, head_time, head_packet,
//                                head_retries, occupancy, status
//
// A command is registered at the edge that accepts it and is applied to the
// cells at the next edge; its result is shown for one cycle after that.
// A command may be accepted in every cycle, so busy stays low.
// Reset empties the queue at once; there is no clearing pass.
// The receiver cannot stall, so each result stands for exactly one cycle.
module retransmit_timer_queue import rtq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [PORT_TIME_BITS-1:0]   due_time,
  input  logic [PORT_HANDLE_BITS-1:0] packet_handle,
  input  logic [RETRY_BITS-1:0]       retry_count,
  output logic                        done,
  output logic                        head_valid,
  output logic [PORT_TIME_BITS-1:0]   head_time,
  output logic [PORT_HANDLE_BITS-1:0] head_packet,
  output logic [RETRY_BITS-1:0]       head_retries,
  output logic [PORT_OCC_BITS-1:0]    occupancy,
  output logic [1:0]                  status
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic                   cmd_valid;
  kind_t                  cmd_kind;
  logic [TIME_BITS-1:0]   cmd_time;
  logic [HANDLE_BITS-1:0] cmd_handle;
  logic [RETRY_BITS-1:0]  cmd_retries;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  status_t       status_reg;
  status_t       status_next;

  cell_ctrl_t ctrl;
  logic       full;
  logic       found;

  logic                   c_valid   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]   c_time    [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] c_handle  [QUEUE_DEPTH];
  logic [RETRY_BITS-1:0]  c_retries [QUEUE_DEPTH];
  logic                   c_le      [QUEUE_DEPTH];
  logic                   c_seen    [QUEUE_DEPTH];

  logic [63:0] time_wide;
  logic [63:0] in_time_wide;
  logic [31:0] handle_wide;
  logic [31:0] in_handle_wide;
  logic [15:0] count_wide;

  assign busy = 1'b0;

  assign in_time_wide   = 64'(due_time);
  assign in_handle_wide = 32'(packet_handle);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_kind    <= kind_t'(kind);
      cmd_time    <= in_time_wide[TIME_BITS-1:0];
      cmd_handle  <= in_handle_wide[HANDLE_BITS-1:0];
      cmd_retries <= retry_count;
    end
  end

  assign full  = c_valid[QUEUE_DEPTH-1];
  assign found = c_seen[QUEUE_DEPTH-1];

  always_comb begin
    ctrl.ins       = cmd_valid && (cmd_kind == KIND_INSERT) && !full;
    ctrl.del       = cmd_valid && ((cmd_kind == KIND_POP) || (cmd_kind == KIND_REMOVE));
    ctrl.by_handle = (cmd_kind == KIND_REMOVE);
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                   p_valid;
      logic [TIME_BITS-1:0]   p_time;
      logic [HANDLE_BITS-1:0] p_handle;
      logic [RETRY_BITS-1:0]  p_retries;
      logic                   p_le;
      logic                   n_valid;
      logic [TIME_BITS-1:0]   n_time;
      logic [HANDLE_BITS-1:0] n_handle;
      logic [RETRY_BITS-1:0]  n_retries;
      logic                   s_in;

      if (i == 0) begin : g_head
        assign p_valid   = 1'b0;
        assign p_time    = '0;
        assign p_handle  = '0;
        assign p_retries = '0;
        assign p_le      = 1'b1;
        assign s_in      = 1'b0;
      end else begin : g_body
        assign p_valid   = c_valid[i-1];
        assign p_time    = c_time[i-1];
        assign p_handle  = c_handle[i-1];
        assign p_retries = c_retries[i-1];
        assign p_le      = c_le[i-1];
        assign s_in      = c_seen[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign n_valid   = 1'b0;
        assign n_time    = '0;
        assign n_handle  = '0;
        assign n_retries = '0;
      end else begin : g_inner
        assign n_valid   = c_valid[i+1];
        assign n_time    = c_time[i+1];
        assign n_handle  = c_handle[i+1];
        assign n_retries = c_retries[i+1];
      end

      rtq_cell #(
        .TIME_BITS   (TIME_BITS),
        .HANDLE_BITS (HANDLE_BITS)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .ctrl          (ctrl),
        .cmd_time      (cmd_time),
        .cmd_handle    (cmd_handle),
        .cmd_retries   (cmd_retries),
        .prev_valid    (p_valid),
        .prev_time     (p_time),
        .prev_handle   (p_handle),
        .prev_retries  (p_retries),
        .prev_le       (p_le),
        .next_valid    (n_valid),
        .next_time     (n_time),
        .next_handle   (n_handle),
        .next_retries  (n_retries),
        .seen_in       (s_in),
        .seen_out      (c_seen[i]),
        .le            (c_le[i]),
        .valid         (c_valid[i]),
        .entry_time    (c_time[i]),
        .entry_handle  (c_handle[i]),
        .entry_retries (c_retries[i])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    status_next = STATUS_DONE;
    unique case (cmd_kind)
      KIND_INSERT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      KIND_POP, KIND_REMOVE: begin
        if (found) begin
          count_next = count - CW'(1);
        end else begin
          status_next = STATUS_MISSING;
        end
      end
      default: begin
        status_next = STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd_valid;
      if (cmd_valid) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      status_reg <= status_next;
    end
  end

  assign time_wide   = 64'(c_time[0]);
  assign handle_wide = 32'(c_handle[0]);
  assign count_wide  = 16'(count);

  assign head_valid   = c_valid[0];
  assign head_time    = c_valid[0] ? time_wide[PORT_TIME_BITS-1:0] : '0;
  assign head_packet  = c_valid[0] ? handle_wide[PORT_HANDLE_BITS-1:0] : '0;
  assign head_retries = c_valid[0] ? c_retries[0] : '0;
  assign occupancy    = count_wide[PORT_OCC_BITS-1:0];
  assign status       = status_reg;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the retransmit timer queue: a table of directed
// transactions, then random insert, pop, remove and peek traffic, each result
// checked against an in-bench sorted-list model. Depends on rtq_pkg and the RTL.
module tb_top import rtq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_SLOTS = QUEUE_DEPTH_DEF;
  localparam int RANDOM_OPS  = 1400;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [PORT_TIME_BITS-1:0]   due;
    logic [PORT_HANDLE_BITS-1:0] handle;
    logic [RETRY_BITS-1:0]       retries;
  } timer_entry_t;

  typedef struct packed {
    logic                        valid;
    logic [PORT_TIME_BITS-1:0]   due;
    logic [PORT_HANDLE_BITS-1:0] handle;
    logic [RETRY_BITS-1:0]       retries;
    logic [PORT_OCC_BITS-1:0]    occ;
    status_t                     stat;
  } head_report_t;

  typedef struct {
    kind_t                       op;
    logic [PORT_TIME_BITS-1:0]   due;
    logic [PORT_HANDLE_BITS-1:0] handle;
    logic [RETRY_BITS-1:0]       retries;
    bit                          fixed;
    head_report_t                want;
  } op_row_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [1:0]                  kind;
  logic [PORT_TIME_BITS-1:0]   due_time;
  logic [PORT_HANDLE_BITS-1:0] packet_handle;
  logic [RETRY_BITS-1:0]       retry_count;
  logic                        done;
  logic                        head_valid;
  logic [PORT_TIME_BITS-1:0]   head_time;
  logic [PORT_HANDLE_BITS-1:0] head_packet;
  logic [RETRY_BITS-1:0]       head_retries;
  logic [PORT_OCC_BITS-1:0]    occupancy;
  logic [1:0]                  status;

  timer_entry_t pending_list[$];
  head_report_t predicted_heads[$];
  op_row_t      directed_rows[$];

  int ops_sent;
  int directed_ops;
  int full_drops;
  int empty_misses;
  int peak_occ;
  int heads_checked;
  int fault_count;
  int stall_cycles;

  retransmit_timer_queue dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .due_time(due_time),
    .packet_handle(packet_handle),
    .retry_count(retry_count),
    .done(done),
    .head_valid(head_valid),
    .head_time(head_time),
    .head_packet(head_packet),
    .head_retries(head_retries),
    .occupancy(occupancy),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic head_report_t make_head(logic v, logic [PORT_TIME_BITS-1:0] t,
                                             logic [PORT_HANDLE_BITS-1:0] h,
                                             logic [RETRY_BITS-1:0] r, int occ,
                                             status_t st);
    head_report_t rep;
    rep.valid   = v;
    rep.due     = t;
    rep.handle  = h;
    rep.retries = r;
    rep.occ     = occ[PORT_OCC_BITS-1:0];
    rep.stat    = st;
    return rep;
  endfunction

  // Applies one operation to the sorted list and returns the head, occupancy and status it leaves.
  function automatic head_report_t apply_queue_op(kind_t op, logic [PORT_TIME_BITS-1:0] t,
                                                  logic [PORT_HANDLE_BITS-1:0] h,
                                                  logic [RETRY_BITS-1:0] r);
    head_report_t rep;
    timer_entry_t ent;
    int pos;
    rep = '0;
    rep.stat = STATUS_DONE;
    case (op)
      KIND_INSERT: begin
        if (pending_list.size() >= QUEUE_SLOTS) begin
          rep.stat = STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < pending_list.size() && pending_list[pos].due <= t) pos++;
          ent.due = t;
          ent.handle = h;
          ent.retries = r;
          pending_list.insert(pos, ent);
        end
      end
      KIND_POP: begin
        if (pending_list.size() == 0) rep.stat = STATUS_MISSING;
        else pending_list.delete(0);
      end
      KIND_REMOVE: begin
        pos = 0;
        while (pos < pending_list.size() && pending_list[pos].handle != h) pos++;
        if (pos < pending_list.size()) pending_list.delete(pos);
        else rep.stat = STATUS_MISSING;
      end
      default: begin
      end
    endcase
    if (pending_list.size() > 0) begin
      rep.valid   = 1'b1;
      rep.due     = pending_list[0].due;
      rep.handle  = pending_list[0].handle;
      rep.retries = pending_list[0].retries;
    end
    rep.occ = PORT_OCC_BITS'(pending_list.size());
    return rep;
  endfunction

  task automatic add_row(kind_t op, logic [PORT_TIME_BITS-1:0] t,
                         logic [PORT_HANDLE_BITS-1:0] h, logic [RETRY_BITS-1:0] r,
                         bit fixed, head_report_t want);
    op_row_t row;
    row.op = op;
    row.due = t;
    row.handle = h;
    row.retries = r;
    row.fixed = fixed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_op(kind_t op, logic [PORT_TIME_BITS-1:0] t,
                         logic [PORT_HANDLE_BITS-1:0] h, logic [RETRY_BITS-1:0] r,
                         bit fixed, head_report_t want);
    head_report_t rep;
    @(negedge clk);
    start <= 1'b1;
    kind <= op;
    due_time <= t;
    packet_handle <= h;
    retry_count <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    rep = apply_queue_op(op, t, h, r);
    if (rep.stat == STATUS_FULL) full_drops++;
    if (rep.stat == STATUS_MISSING) empty_misses++;
    if (int'(rep.occ) > peak_occ) peak_occ = int'(rep.occ);
    predicted_heads.push_back(fixed ? want : rep);
    ops_sent++;
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (predicted_heads.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int w;
    w = $urandom_range(0, 99);
    if (w < 60) return 0;
    if (w < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic kind_t pick_op(op_mix_t mix);
    int w;
    w = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return w < 75 ? KIND_INSERT : w < 85 ? KIND_POP : w < 95 ? KIND_REMOVE : KIND_PEEK;
      MIX_DRAIN: return w < 20 ? KIND_INSERT : w < 60 ? KIND_POP : w < 90 ? KIND_REMOVE : KIND_PEEK;
      default:   return w < 40 ? KIND_INSERT : w < 65 ? KIND_POP : w < 90 ? KIND_REMOVE : KIND_PEEK;
    endcase
  endfunction

  // Narrow time ranges give plenty of ties; the rest spans the full width.
  function automatic logic [PORT_TIME_BITS-1:0] pick_due();
    int w;
    w = $urandom_range(0, 9);
    if (w < 4) return $urandom_range(0, 15);
    if (w == 4) return $urandom_range(0, 1) ? '1 : '0;
    return $urandom;
  endfunction

  function automatic logic [PORT_HANDLE_BITS-1:0] pick_handle(kind_t op);
    int w;
    w = $urandom_range(0, 99);
    if (op == KIND_REMOVE && pending_list.size() > 0 && w < 60)
      return pending_list[$urandom_range(0, pending_list.size() - 1)].handle;
    if (w < 80) return PORT_HANDLE_BITS'($urandom_range(0, 7));
    return PORT_HANDLE_BITS'($urandom);
  endfunction

  always @(posedge clk) begin : result_check
    head_report_t seen;
    head_report_t want;
    bit bad;
    if (!rst && done) begin
      seen = make_head(head_valid, head_time, head_packet, head_retries, occupancy,
                       status_t'(status));
      if (predicted_heads.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("Unexpected result at %0t: valid %0d time %h handle %h retries %h occ %0d",
                   $realtime, seen.valid, seen.due, seen.handle, seen.retries, seen.occ);
      end else begin
        want = predicted_heads.pop_front();
        heads_checked++;
        bad = (seen.valid !== want.valid) || (seen.due !== want.due) ||
              (seen.handle !== want.handle) || (seen.retries !== want.retries) ||
              (seen.occ !== want.occ) || (seen.stat !== want.stat);
        if (bad) begin
          fault_count++;
          if (fault_count <= 10)
            $display("Mismatch at %0t: expected %0d/%h/%h/%h/%0d/%0d, got %0d/%h/%h/%h/%0d/%0d",
                     $realtime, want.valid, want.due, want.handle, want.retries, want.occ,
                     want.stat, seen.valid, seen.due, seen.handle, seen.retries, seen.occ,
                     seen.stat);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timed out with %0d results outstanding.", predicted_heads.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    head_report_t none;
    op_mix_t mix;
    kind_t op;
    int burst;
    bit steady;
    int n;
    none = '0;
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_PEEK;
    due_time = '0;
    packet_handle = '0;
    retry_count = '0;
    ops_sent = 0;
    full_drops = 0;
    empty_misses = 0;
    peak_occ = 0;
    heads_checked = 0;
    fault_count = 0;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_row(KIND_PEEK, '0, '0, '0, 1'b1, make_head(1'b0, '0, '0, '0, 0, STATUS_DONE));
    add_row(KIND_POP, '0, '0, '0, 1'b1, make_head(1'b0, '0, '0, '0, 0, STATUS_MISSING));
    add_row(KIND_REMOVE, '0, 16'h0003, '0, 1'b1,
            make_head(1'b0, '0, '0, '0, 0, STATUS_MISSING));
    add_row(KIND_INSERT, '1, '1, '1, 1'b1, make_head(1'b1, '1, '1, '1, 1, STATUS_DONE));
    add_row(KIND_INSERT, '0, '0, '0, 1'b1, make_head(1'b1, '0, '0, '0, 2, STATUS_DONE));
    add_row(KIND_INSERT, '0, 16'h0001, 8'h01, 1'b0, none);
    add_row(KIND_REMOVE, '0, 16'h0000, '0, 1'b0, none);
    add_row(KIND_REMOVE, '0, 16'h5a5a, '0, 1'b0, none);
    add_row(KIND_PEEK, '0, '0, '0, 1'b0, none);
    for (int i = 0; i < QUEUE_SLOTS - 2; i++)
      add_row(KIND_INSERT, 32'h8000_0000 - i * 32'h0101_0101,
              PORT_HANDLE_BITS'(16'h0100 + i), RETRY_BITS'(i), 1'b0, none);
    add_row(KIND_INSERT, 32'h0000_0005, 16'h00aa, 8'h55, 1'b1,
            make_head(1'b1, '0, 16'h0001, 8'h01, QUEUE_SLOTS, STATUS_FULL));
    add_row(KIND_POP, '0, '0, '0, 1'b0, none);

    foreach (directed_rows[i]) begin
      send_op(directed_rows[i].op, directed_rows[i].due, directed_rows[i].handle,
              directed_rows[i].retries, directed_rows[i].fixed, directed_rows[i].want);
      if (i % 4 == 3) idle_for(pick_gap());
    end
    directed_ops = ops_sent;
    wait_drained();

    while (ops_sent < directed_ops + RANDOM_OPS) begin
      mix = op_mix_t'($urandom_range(0, 2));
      burst = $urandom_range(20, 80);
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst; i++) begin
        op = pick_op(mix);
        send_op(op, pick_due(), pick_handle(op), RETRY_BITS'($urandom), 1'b0, none);
        if (!steady) begin
          n = pick_gap();
          idle_for(n);
        end
      end
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    fault_count += predicted_heads.size();
    $display("Ran %0d transactions (%0d from the table), checked %0d results, peak occupancy %0d.",
             ops_sent, directed_ops, heads_checked, peak_occ);
    $display("Inserts dropped on a full queue: %0d; pops or removes that found nothing: %0d.",
             full_drops, empty_misses);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("Failures: %0d.", fault_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
